// ===== hw/rtl/piecewise_linear_interp_assert.svh =====
// Assertion macros used by the checker of the interpolator.
// Both sample on clk and are disabled while rst_n is low.
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// Same-cycle implication.
`define PLI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_EVAL  = 1'b1;

    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    localparam logic [1:0] REG_NUM_POINTS_ADDR = 2'd0;
    localparam logic [4:0] NUM_POINTS_RESET    = 5'd1;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] slope;
        logic [1:0]         region;
        logic               saturated;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       wr_point;
        logic       start;
        logic       addr_inc;
        logic       addr_dec;
        logic       latch_hi;
        logic       latch_lo;
        logic       set_clamp;
        logic [1:0] region;
        logic       prep;
        logic       div_start;
        logic       load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic at_first;
        logic at_last;
        logic div_done;
    } status_t;

endpackage

// ===== hw/rtl/pli_muldiv.sv =====
`timescale 1ns / 1ps

// Computes floor(m * t / d) one bit of m per cycle, MSB first.
// Requires t <= d. Remainder kept below d, so each step yields a digit 0..2.
module pli_muldiv #(
    parameter int MW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] m,
    input  logic [32:0]   t,
    input  logic [32:0]   d,
    output logic          busy,
    output logic [32:0]   q,
    output logic          ovf
);

    localparam int CNT_W = $clog2(MW + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MW-1:0]    m_reg, m_next;
    logic [32:0]      r_reg, r_next;
    logic [32:0]      q_reg, q_next;
    logic             ovf_reg, ovf_next;

    logic [34:0] v, d1, d2;
    logic [34:0] q_full;
    logic [1:0]  dig;

    always_comb
    begin
        v  = {1'b0, r_reg, 1'b0} + (m_reg[MW-1] ? {2'b00, t} : 35'd0);
        d1 = {2'b00, d};
        d2 = {1'b0, d, 1'b0};
        if (v >= d2)
        begin
            dig    = 2'd2;
            r_next = 33'(v - d2);
        end
        else if (v >= d1)
        begin
            dig    = 2'd1;
            r_next = 33'(v - d1);
        end
        else
        begin
            dig    = 2'd0;
            r_next = v[32:0];
        end
        q_full    = {1'b0, q_reg, 1'b0} + 35'(dig);
        q_next    = q_full[32:0];
        ovf_next  = ovf_reg | (q_full[34:33] != 2'b00);
        m_next    = m_reg << 1;
        cnt_next  = cnt_reg - CNT_W'(1);
        busy_next = (cnt_reg != CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(MW);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= m;
            r_reg   <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            m_reg   <= m_next;
            r_reg   <= r_next;
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
        end
    end

    assign busy = busy_reg;
    assign q    = q_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== hw/rtl/pli_datapath.sv =====
`timescale 1ns / 1ps

module pli_datapath #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = pli_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pli_pkg::in_item_t in_data,
    input  logic [4:0]        num_points,
    input  pli_pkg::cmd_t     cmd,
    output pli_pkg::status_t  status,
    output pli_pkg::out_item_t out_data
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int NW  = (CW > 5) ? CW : 5;
    localparam int MWS = 33 + FRAC_BITS;

    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];

    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0]      addr_reg, last_reg;
    logic signed [31:0] sample_reg;
    logic signed [31:0] x1_reg, y1_reg, x0_reg, y0_reg;
    logic [1:0]         region_reg;
    logic [32:0]        dx_reg, t_reg;
    logic signed [32:0] dy_reg;
    pli_pkg::out_item_t out_reg, out_next;

    logic [NW-1:0]      np_ext, n_eff;
    logic [AW-1:0]      last_next;
    logic               wr_in_range;
    logic [32:0]        a_mag;
    logic               dy_neg;

    logic               busy_v, busy_s, ovf_v, ovf_s;
    logic [32:0]        q_v, q_s;

    logic signed [33:0] y0_ext, frac_ext, v_sum;
    logic               v_sat, s_sat;
    logic signed [31:0] v_clip, s_clip;

    // effective point count: zero reads as one, capped at table depth
    always_comb
    begin
        np_ext = NW'(num_points);
        if (np_ext == '0)
            n_eff = NW'(1);
        else if (np_ext > NW'(MAX_POINTS))
            n_eff = NW'(MAX_POINTS);
        else
            n_eff = np_ext;
        last_next = AW'(n_eff - NW'(1));
    end

    assign wr_in_range = (32'(in_data.point_index) < 32'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_point && wr_in_range)
        begin
            x_mem[AW'(in_data.point_index)] <= in_data.point_x;
            y_mem[AW'(in_data.point_index)] <= in_data.point_y;
        end
        rd_x_reg <= x_mem[addr_reg];
        rd_y_reg <= y_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sample_reg <= in_data.sample;
            addr_reg   <= '0;
            last_reg   <= last_next;
        end
        else if (cmd.addr_inc)
            addr_reg <= addr_reg + AW'(1);
        else if (cmd.addr_dec)
            addr_reg <= addr_reg - AW'(1);

        if (cmd.latch_hi)
        begin
            x1_reg <= rd_x_reg;
            y1_reg <= rd_y_reg;
        end
        if (cmd.set_clamp)
        begin
            y0_reg     <= rd_y_reg;
            region_reg <= cmd.region;
        end
        else if (cmd.latch_lo)
        begin
            x0_reg     <= rd_x_reg;
            y0_reg     <= rd_y_reg;
            region_reg <= pli_pkg::REGION_INSIDE;
        end
        if (cmd.prep)
        begin
            dx_reg <= 33'(33'(x1_reg) - 33'(x0_reg));
            t_reg  <= 33'(33'(sample_reg) - 33'(x0_reg));
            dy_reg <= 33'(y1_reg) - 33'(y0_reg);
        end
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign dy_neg = dy_reg[32];
    assign a_mag  = dy_neg ? 33'(-dy_reg) : 33'(dy_reg);

    // fraction of the segment rise: floor(|dy| * t / dx)
    pli_muldiv #(
        .MW(33)
    ) u_div_value (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .m    (a_mag),
        .t    (t_reg),
        .d    (dx_reg),
        .busy (busy_v),
        .q    (q_v),
        .ovf  (ovf_v)
    );

    // slope magnitude: floor(|dy| * 2^FRAC_BITS / dx)
    pli_muldiv #(
        .MW(MWS)
    ) u_div_slope (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .m    (MWS'(a_mag) << FRAC_BITS),
        .t    (33'd1),
        .d    (dx_reg),
        .busy (busy_s),
        .q    (q_s),
        .ovf  (ovf_s)
    );

    always_comb
    begin
        y0_ext   = 34'(y0_reg);
        frac_ext = signed'({1'b0, q_v});
        v_sum    = dy_neg ? (y0_ext - frac_ext) : (y0_ext + frac_ext);
        // value cannot leave [y0, y1] when ovf_v is clear; kept as a guard
        v_sat    = ovf_v || (v_sum > 34'sh0_7FFF_FFFF) || (v_sum < 34'sh3_8000_0000);
        if (ovf_v)
            v_clip = dy_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (v_sum > 34'sh0_7FFF_FFFF)
            v_clip = 32'sh7FFF_FFFF;
        else if (v_sum < 34'sh3_8000_0000)
            v_clip = 32'sh8000_0000;
        else
            v_clip = v_sum[31:0];

        s_sat = ovf_s || (!dy_neg && (q_s > 33'h0_7FFF_FFFF))
                      || (dy_neg && (q_s > 33'h0_8000_0000));
        if (s_sat)
            s_clip = dy_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (dy_neg)
            s_clip = -signed'(q_s[31:0]);
        else
            s_clip = signed'(q_s[31:0]);

        if (region_reg == pli_pkg::REGION_INSIDE)
        begin
            out_next.value     = v_clip;
            out_next.slope     = s_clip;
            out_next.saturated = v_sat | s_sat;
        end
        else
        begin
            out_next.value     = y0_reg;
            out_next.slope     = '0;
            out_next.saturated = 1'b0;
        end
        out_next.region = region_reg;
    end

    assign status.hit      = (sample_reg < rd_x_reg);
    assign status.at_first = (addr_reg == '0);
    assign status.at_last  = (addr_reg == last_reg);
    assign status.div_done = !busy_v && !busy_s;

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/pli_ctrl.sv =====
`timescale 1ns / 1ps

module pli_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_req,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  pli_pkg::status_t status,
    output pli_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_READ_LO,
        S_LATCH_LO,
        S_PREP,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req == pli_pkg::REQ_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_READ;
                    end
                    else
                        cmd.wr_point = 1'b1;
                end
            end
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                if (status.hit)
                begin
                    if (status.at_first)
                    begin
                        cmd.set_clamp = 1'b1;
                        cmd.region    = pli_pkg::REGION_BELOW;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        cmd.latch_hi = 1'b1;
                        cmd.addr_dec = 1'b1;
                        state_next   = S_READ_LO;
                    end
                end
                else if (status.at_last)
                begin
                    cmd.set_clamp = 1'b1;
                    cmd.region    = pli_pkg::REGION_ABOVE;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ_LO:
                state_next = S_LATCH_LO;
            S_LATCH_LO:
            begin
                cmd.latch_lo = 1'b1;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/piecewise_linear_interp.sv =====
// Point write: the next item is taken on the following cycle.
// Evaluate: scans the table to the bracketing point, then inside a segment fetches
//   the lower point and waits on both dividers, of which the slope divider is longer.
// One item in flight; the finished result waits in the output register meanwhile.
// rst_n (async, active low) clears control state and sets num_points to 1;
//   point tables are not cleared and hold nothing valid until written.
`timescale 1ns / 1ps

module piecewise_linear_interp #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = pli_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  pli_pkg::in_item_t  in_data,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output pli_pkg::out_item_t out_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration: a single register, num_points, at byte address 0.
    // Writes land on the access phase; the port never inserts wait states.
    logic [4:0] num_points_reg, num_points_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == pli_pkg::REG_NUM_POINTS_ADDR);

    always_comb
    begin
        num_points_next = cfg_wr ? pwdata[4:0] : num_points_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_points_reg <= pli_pkg::NUM_POINTS_RESET;
        else
            num_points_reg <= num_points_next;
    end

    assign prdata = (paddr == pli_pkg::REG_NUM_POINTS_ADDR) ? 32'(num_points_reg) : 32'd0;

    // Controller sequences the scan, the bracket fetch, the divide and the
    // result transfer; datapath holds the tables, the divider pair and the
    // output register.
    pli_pkg::cmd_t    cmd;
    pli_pkg::status_t status;

    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_req   (in_data.req_type),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pli_datapath #(
        .MAX_POINTS(MAX_POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .num_points(num_points_reg),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/pli_checker.sv =====
`timescale 1ns / 1ps
`include "piecewise_linear_interp_assert.svh"

module pli_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input pli_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input pli_pkg::out_item_t out_data
);

    logic in_xfer;
    logic is_eval;
    logic out_wait;

    assign in_xfer  = in_valid && !in_stall;
    assign is_eval  = (in_data.req_type == pli_pkg::REQ_EVAL);
    assign out_wait = out_valid && out_stall;

    `PLI_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled result moved")
    `PLI_ASSERT_NEXT(a_eval_busy, in_xfer && is_eval, in_stall, "evaluate left block idle")
    `PLI_ASSERT_NEXT(a_write_fast, in_xfer && !is_eval, !in_stall, "point write stalled input")
    `PLI_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(in_stall), "result without evaluation")

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
